/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL; they vanish in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

/* rtl/afpp_pkg.sv */
// Types and constants of the ASCII field packet parser.
package afpp_pkg;

  typedef enum logic [1:0] {
    OP_SERIAL = 2'd0,
    OP_RADIO  = 2'd1,
    OP_TICK   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    LINK_NONE   = 2'd0,
    LINK_SERIAL = 2'd1,
    LINK_RADIO  = 2'd2
  } link_e;

  // atol-style conversion phases
  typedef enum logic [2:0] {
    PH_SKIP = 3'b001,
    PH_NUM  = 3'b010,
    PH_DONE = 3'b100
  } phase_e;

  localparam logic [7:0]  CH_START        = 8'h24;
  localparam logic [7:0]  CH_END          = 8'h3B;
  localparam logic [7:0]  CH_SPACE        = 8'h20;
  localparam logic [7:0]  CH_PLUS         = 8'h2B;
  localparam logic [7:0]  CH_MINUS        = 8'h2D;
  localparam logic [15:0] DEFAULT_TIMEOUT = 16'd3500;
  localparam logic [15:0] IDLE_MAX        = 16'hFFFF;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic               field_valid;
    logic [2:0]         field_index;
    logic signed [15:0] field_value;
    logic               packet_end;
    logic [1:0]         link_mode;
  } out_item_t;

endpackage

/* rtl/afpp_core.sv */
// Parser and link supervision state with the per-item update logic.
module afpp_core import afpp_pkg::*; #(
  parameter int MAX_FIELDS = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  in_item_t    item_i,
  input  logic [15:0] timeout_i,
  output out_item_t   result_o
);

  logic        in_packet_q, in_packet_d;
  logic [2:0]  pos_q, pos_d;
  logic [15:0] acc_q, acc_d;
  logic        neg_q, neg_d;
  phase_e      phase_q, phase_d;
  logic        serial_q, serial_d;
  logic        radio_q, radio_d;
  logic [15:0] idle_q, idle_d;

  logic [7:0]  c;
  logic        is_digit;
  logic        is_ws;
  logic [15:0] acc_x10;

  assign c        = item_i.byte_value;
  assign is_digit = (c >= 8'h30) && (c <= 8'h39);
  assign is_ws    = (c >= 8'h09) && (c <= 8'h0D);
  assign acc_x10  = {acc_q[12:0], 3'b000} + {acc_q[14:0], 1'b0};

  always_comb begin
    in_packet_d = in_packet_q;
    pos_d       = pos_q;
    acc_d       = acc_q;
    neg_d       = neg_q;
    phase_d     = phase_q;
    serial_d    = serial_q;
    radio_d     = radio_q;
    idle_d      = idle_q;

    result_o.field_valid = 1'b0;
    result_o.field_index = 3'd0;
    result_o.field_value = 16'sd0;
    result_o.packet_end  = 1'b0;

    unique case (item_i.operation)
      OP_SERIAL: begin
        if (!radio_q) begin
          if (in_packet_q) begin
            if (c != CH_SPACE && c != CH_END) begin
              if (phase_q != PH_DONE) begin
                if (is_digit) begin
                  acc_d   = acc_x10 + {12'd0, c[3:0]};
                  phase_d = PH_NUM;
                end else if (phase_q == PH_SKIP && is_ws) begin
                  phase_d = PH_SKIP;
                end else if (phase_q == PH_SKIP && (c == CH_PLUS || c == CH_MINUS)) begin
                  neg_d   = (c == CH_MINUS);
                  phase_d = PH_NUM;
                end else begin
                  phase_d = PH_DONE;
                end
              end
            end else begin
              // field closes; extra fields beyond the limit are dropped
              if (pos_q < 3'(MAX_FIELDS)) begin
                result_o.field_valid = 1'b1;
                result_o.field_index = pos_q;
                result_o.field_value = neg_q ? (16'sd0 - $signed(acc_q)) : $signed(acc_q);
                pos_d = pos_q + 3'd1;
              end
              acc_d   = 16'd0;
              neg_d   = 1'b0;
              phase_d = PH_SKIP;
            end
          end
          if (c == CH_START) begin
            in_packet_d = 1'b1;
            pos_d       = 3'd0;
            acc_d       = 16'd0;
            neg_d       = 1'b0;
            phase_d     = PH_SKIP;
          end
          if (c == CH_END) begin
            in_packet_d         = 1'b0;
            serial_d            = 1'b1;
            idle_d              = 16'd0;
            result_o.packet_end = 1'b1;
          end
        end
      end
      OP_RADIO: begin
        if (!serial_q) begin
          radio_d = 1'b1;
          idle_d  = 16'd0;
        end
      end
      OP_TICK: begin
        if (idle_q != IDLE_MAX) begin
          idle_d = idle_q + 16'd1;
        end
        if ((serial_q || radio_q) && idle_d > timeout_i) begin
          serial_d = 1'b0;
          radio_d  = 1'b0;
        end
      end
      default: ;
    endcase

    priority if (serial_d) begin
      result_o.link_mode = LINK_SERIAL;
    end else if (radio_d) begin
      result_o.link_mode = LINK_RADIO;
    end else begin
      result_o.link_mode = LINK_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_packet_q <= 1'b0;
      pos_q       <= 3'd0;
      acc_q       <= 16'd0;
      neg_q       <= 1'b0;
      phase_q     <= PH_SKIP;
      serial_q    <= 1'b0;
      radio_q     <= 1'b0;
      idle_q      <= 16'd0;
    end else if (step_i) begin
      in_packet_q <= in_packet_d;
      pos_q       <= pos_d;
      acc_q       <= acc_d;
      neg_q       <= neg_d;
      phase_q     <= phase_d;
      serial_q    <= serial_d;
      radio_q     <= radio_d;
      idle_q      <= idle_d;
    end
  end

endmodule

/* rtl/ascii_field_packet_parser.sv */
// ASCII field packet parser, top level: input and result registers, timeout register.
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one request per item:
//   a serial character, a radio frame event or a one millisecond tick.
//   Output channel (out_valid_o / out_stall_i / out_data_o) returns exactly one
//   result per request: an optional completed field with its index and value,
//   the end-of-packet flag and the link mode after the update.
//   The timeout register is written through cfg_valid_i / cfg_data_i; cfg_ready_o
//   is always high. Write it only while no request is in flight.
// Timing:
//   A request accepted into the input register is processed into the result register
//   once that register is free or being drained, and is then shown on out_valid_o.
//   One request per cycle is sustained while the receiver does not stall; the parser
//   state registers update at the same edge as the result register is written.
// Reset clears the parser and link state, empties both registers and loads a
// timeout of 3500 ms. When the receiver stalls, the result register holds its
// value, the input register still takes one request, and then in_stall_o rises.
`include "assert_macros.svh"

module ascii_field_packet_parser import afpp_pkg::*; #(
  parameter int MAX_FIELDS = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic        in_valid_q, in_valid_d;
  in_item_t    in_item_q;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_item_q;
  logic [15:0] timeout_q;

  logic        advance;
  logic        in_accept;
  logic        step;
  out_item_t   result;
  logic        field_out;
  logic        end_out;

  // result register free or being drained this cycle
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign step       = in_valid_q && advance;

  assign in_valid_d  = in_accept || (in_valid_q && !advance);
  assign out_valid_d = step || (out_valid_q && out_stall_i);

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

  assign field_out = out_valid_q && out_item_q.field_valid;
  assign end_out   = out_valid_q && out_item_q.packet_end;

  afpp_core #(
    .MAX_FIELDS(MAX_FIELDS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_item_q),
    .timeout_i(timeout_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      timeout_q   <= DEFAULT_TIMEOUT;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        timeout_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_item_q <= in_data_i;
    end
    if (step) begin
      out_item_q <= result;
    end
  end

  `ASSERT_IMPLY(a_stall_only_when_full, clk_i, rst_ni, in_stall_o, in_valid_q)
  `ASSERT_IMPLY(a_index_in_range, clk_i, rst_ni, field_out, out_item_q.field_index < 3'(MAX_FIELDS))
  `ASSERT_IMPLY(a_end_sets_serial, clk_i, rst_ni, end_out, out_item_q.link_mode == LINK_SERIAL)
  `ASSERT_IMPLY(a_field_not_radio, clk_i, rst_ni, field_out, out_item_q.link_mode != LINK_RADIO)
  `ASSERT_NEXT(a_step_fills_result, clk_i, rst_ni, step, out_valid_q)

endmodule
